/* rtl/core/sqb_pkg.sv */
// Shared types and constants of the sprite quad batcher.
package sqb_pkg;

   localparam int TEXTURE_SLOTS_DEF    = 32;
   localparam int MAX_BATCH_QUADS_DEF  = 65536;
   localparam int SINE_TABLE_DEPTH_DEF = 256;

   localparam logic REQ_DRAW = 1'b0;
   localparam logic REQ_END  = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic signed [23:0] center_x;
      logic signed [23:0] center_y;
      logic signed [15:0] depth_z;
      logic [22:0]        width;
      logic [22:0]        height;
      logic [15:0]        angle;
      logic [15:0]        texture_id;
      logic [31:0]        color_rgba;
   } sqb_req_type;

   typedef struct packed {
      logic signed [23:0] vertex_x;
      logic signed [23:0] vertex_y;
      logic signed [15:0] vertex_z;
      logic               tex_u;
      logic               tex_v;
      logic [4:0]         tex_slot;
      logic [31:0]        vertex_color;
      logic               batch_break;
      logic               batch_end_only;
      logic [16:0]        closed_quads;
      logic               last;
   } sqb_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SIN,
      ST_COS,
      ST_MUL,
      ST_EMIT,
      ST_END
   } sqb_state_type;

endpackage

/* rtl/core/sqb_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module sqb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

/* rtl/core/sprite_quad_batcher_core.sv */
// Top level of the sprite quad batcher: slot lookup, rotation and vertex output.
//
//  channel | direction | handshake             | beat
//  req_    | in        | req_valid / req_ready | one quad or one end request
//  rsp_    | out       | rsp_valid / rsp_ready | one vertex, or one end report
//
// A draw request is accepted, searches the slot table unless its texture id is 0
// (one slot table read per cycle in the RAM, over the slots in use), looks up
// sine and cosine, forms four products on the single shared multiplier and
// sends 4 beats of output. An end request sends one end report.
// Reset is synchronous; it empties the batch
// and leaves slot 0 as the only slot in use. The slot table RAM is not
// cleared, since only entries written in the current batch are ever read.
// A stalled output holds its beat in the output register and halts the emit step.
module sprite_quad_batcher_core #(
   parameter int TEXTURE_SLOTS    = sqb_pkg::TEXTURE_SLOTS_DEF,
   parameter int MAX_BATCH_QUADS  = sqb_pkg::MAX_BATCH_QUADS_DEF,
   parameter int SINE_TABLE_DEPTH = sqb_pkg::SINE_TABLE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sqb_pkg::sqb_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sqb_pkg::sqb_rsp_type rsp_data
);
   import sqb_pkg::*;

   localparam int SLOT_W = $clog2(TEXTURE_SLOTS);
   localparam int QUAD_W = $clog2(MAX_BATCH_QUADS + 1);
   localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
   localparam int PH_W   = $clog2(4 * SINE_TABLE_DEPTH);
   localparam int PM_W   = 16 + PH_W;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam logic [PH_W:0] D1 = (PH_W+1)'(SINE_TABLE_DEPTH);
   localparam logic [PH_W:0] D2 = (PH_W+1)'(2 * SINE_TABLE_DEPTH);
   localparam logic [PH_W:0] D3 = (PH_W+1)'(3 * SINE_TABLE_DEPTH);
   localparam logic [PH_W:0] D4 = (PH_W+1)'(4 * SINE_TABLE_DEPTH);
   localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(TEXTURE_SLOTS - 1);
   localparam logic [QUAD_W-1:0] QUAD_LIMIT = QUAD_W'(MAX_BATCH_QUADS);

   // Restoring division, used only while the sine table is built at elaboration.
   function automatic longint unsigned const_udiv(input longint unsigned num,
                                                  input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Quarter-wave sine entry, round(32768*sin(pi/2*k/D)) by an integer
   // Taylor series with 30 fraction bits; evaluated only at elaboration.
   function automatic logic [14:0] sine_entry(input int k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sm;
      longint unsigned e;
      bit              neg;
      x    = const_udiv(HALF_PI_Q30 * longint'(k), 64'(SINE_TABLE_DEPTH));
      x2   = (x * x) >> 30;
      term = x;
      sm   = longint'(x);
      neg  = 1'b1;
      for (int n = 1; n < 24; n++) begin
         term = const_udiv((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
         sm   = neg ? sm - longint'(term) : sm + longint'(term);
         neg  = !neg;
      end
      if (sm < 0) begin
         sm = 0;
      end
      e = (longint'(sm) + 64'd16384) >> 15;
      return (e > 64'd32767) ? 15'd32767 : e[14:0];
   endfunction

   logic [14:0] sine_rom [SINE_TABLE_DEPTH];
   for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
      localparam logic [14:0] ENTRY = sine_entry(g);
      assign sine_rom[g] = ENTRY;
   end

   // Control state.
   sqb_state_type state_ff, state_in;
   logic [1:0]        cnt_ff;
   logic [SLOT_W-1:0] slots_ff;
   logic [QUAD_W-1:0] quads_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic              cmp_vld_ff;
   logic              rsp_valid_ff;

   // Payload of the quad at work.
   sqb_req_type          req_ff;
   logic                 brk_ff;
   logic [QUAD_W-1:0]    closed_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [SLOT_W-1:0]    cmp_idx_ff;
   logic [PH_W-1:0]      phase_ff;
   logic signed [16:0]   sin_ff;
   logic signed [16:0]   cos_ff;
   logic signed [40:0]   prod_ff [4];
   sqb_rsp_type          rsp_ff;

   // Controls from the output decoder.
   logic accept;
   logic out_free;
   logic ram_rd;
   logic ram_wr;
   logic found;
   logic miss;
   logic load_sin;
   logic load_cos;
   logic do_mul;
   logic do_emit;
   logic do_end;
   logic [15:0] ram_rdata;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign found    = cmp_vld_ff && (ram_rdata == req_ff.texture_id);
   assign miss     = !cmp_vld_ff && (idx_ff == slots_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.req_type == REQ_END) begin
                  state_in = ST_END;
               end else if (req_data.texture_id == 16'd0) begin
                  state_in = ST_SIN;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (found || miss) begin
               state_in = ST_SIN;
            end
         end
         ST_SIN:  state_in = ST_COS;
         ST_COS:  state_in = ST_MUL;
         ST_MUL: begin
            if (cnt_ff == 2'd3) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && cnt_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         ST_END: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ram_rd    = 1'b0;
      ram_wr    = 1'b0;
      load_sin  = 1'b0;
      load_cos  = 1'b0;
      do_mul    = 1'b0;
      do_emit   = 1'b0;
      do_end    = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SEARCH: begin
            ram_rd = !found && (idx_ff != slots_ff);
            ram_wr = !found && miss;
         end
         ST_SIN:    load_sin = 1'b1;
         ST_COS:    load_cos = 1'b1;
         ST_MUL:    do_mul   = 1'b1;
         ST_EMIT:   do_emit  = out_free;
         ST_END:    do_end   = out_free;
         default:   req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   sqb_ram #(
      .WIDTH (16),
      .DEPTH (TEXTURE_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (slots_ff),
      .wr_data (req_ff.texture_id),
      .rd_en   (ram_rd),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   // Phase of the request angle: (angle * 4D) >> 16, always below 4D.
   logic [PM_W-1:0] phase_prod;
   assign phase_prod = PM_W'(req_data.angle) * PM_W'(4 * SINE_TABLE_DEPTH);

   // Quarter-wave lookup: sine at the phase, cosine a quarter turn later.
   logic [PH_W:0]      trig_arg;
   logic [PH_W:0]      cos_arg;
   logic [PH_W:0]      trig_rem;
   logic [1:0]         trig_quad;
   logic [PH_W:0]      mirror;
   logic signed [16:0] trig_mag;
   logic signed [16:0] trig_val;

   always_comb begin
      cos_arg = {1'b0, phase_ff} + D1;
      if (cos_arg >= D4) begin
         cos_arg = cos_arg - D4;
      end
      trig_arg = load_cos ? cos_arg : {1'b0, phase_ff};
      if (trig_arg >= D3) begin
         trig_quad = 2'd3;
         trig_rem  = trig_arg - D3;
      end else if (trig_arg >= D2) begin
         trig_quad = 2'd2;
         trig_rem  = trig_arg - D2;
      end else if (trig_arg >= D1) begin
         trig_quad = 2'd1;
         trig_rem  = trig_arg - D1;
      end else begin
         trig_quad = 2'd0;
         trig_rem  = trig_arg;
      end
      mirror = D1 - trig_rem;
      if (trig_quad[0]) begin
         if (trig_rem == '0) begin
            trig_mag = 17'sd32768;
         end else begin
            trig_mag = signed'({2'b00, sine_rom[mirror[IDX_W-1:0]]});
         end
      end else begin
         trig_mag = signed'({2'b00, sine_rom[trig_rem[IDX_W-1:0]]});
      end
      trig_val = trig_quad[1] ? -trig_mag : trig_mag;
   end

   // Shared multiplier: w*cos, h*sin, w*sin, h*cos in turn.
   logic signed [23:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [40:0] mul_p;
   assign mul_a = signed'({1'b0, cnt_ff[0] ? req_ff.height : req_ff.width});
   assign mul_b = (cnt_ff == 2'd0 || cnt_ff == 2'd3) ? cos_ff : sin_ff;
   assign mul_p = 41'(mul_a) * 41'(mul_b);

   // Vertex of corner cnt_ff; bit 0 selects +x, bit 1 selects +y.
   logic signed [42:0] pa, pb, pc, pd;
   logic signed [42:0] ox_sum, oy_sum;
   logic signed [43:0] vx, vy;
   logic signed [23:0] vx_sat, vy_sat;
   logic [SLOT_W+4:0]  slot_ext;
   logic [QUAD_W+16:0] closed_ext;

   always_comb begin
      pa = 43'(prod_ff[0]);
      pb = 43'(prod_ff[1]);
      pc = 43'(prod_ff[2]);
      pd = 43'(prod_ff[3]);
      ox_sum = (cnt_ff[0] ? pa : -pa) - (cnt_ff[1] ? pb : -pb) + 43'sd32768;
      oy_sum = (cnt_ff[0] ? pc : -pc) + (cnt_ff[1] ? pd : -pd) + 43'sd32768;
      vx = 44'(req_ff.center_x) + 44'(ox_sum >>> 16);
      vy = 44'(req_ff.center_y) + 44'(oy_sum >>> 16);
      if (vx > 44'sd8388607) begin
         vx_sat = 24'sh7FFFFF;
      end else if (vx < -44'sd8388608) begin
         vx_sat = 24'sh800000;
      end else begin
         vx_sat = vx[23:0];
      end
      if (vy > 44'sd8388607) begin
         vy_sat = 24'sh7FFFFF;
      end else if (vy < -44'sd8388608) begin
         vy_sat = 24'sh800000;
      end else begin
         vy_sat = vy[23:0];
      end
      slot_ext   = {5'b0, slot_ff};
      closed_ext = {17'b0, closed_ff};
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 2'd0;
         slots_ff     <= SLOT_W'(1);
         quads_ff     <= '0;
         idx_ff       <= SLOT_W'(1);
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_emit || do_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (do_mul || do_emit) begin
            cnt_ff <= cnt_ff + 2'd1;
         end
         if (accept) begin
            idx_ff     <= SLOT_W'(1);
            cmp_vld_ff <= 1'b0;
            if (req_data.req_type == REQ_END) begin
               quads_ff <= '0;
               slots_ff <= SLOT_W'(1);
            end else if (quads_ff >= QUAD_LIMIT || slots_ff >= SLOT_LIMIT) begin
               // The batch is full: close it before this quad is placed.
               quads_ff <= QUAD_W'(1);
               slots_ff <= SLOT_W'(1);
            end else begin
               quads_ff <= quads_ff + QUAD_W'(1);
            end
         end
         if (ram_rd) begin
            idx_ff     <= idx_ff + SLOT_W'(1);
            cmp_vld_ff <= 1'b1;
         end else if (state_ff == ST_SEARCH) begin
            cmp_vld_ff <= 1'b0;
         end
         if (ram_wr) begin
            slots_ff <= slots_ff + SLOT_W'(1);
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff   <= req_data;
         phase_ff <= phase_prod[PM_W-1:16];
         slot_ff  <= '0;
         if (req_data.req_type == REQ_END) begin
            brk_ff    <= 1'b1;
            closed_ff <= quads_ff;
         end else if (quads_ff >= QUAD_LIMIT || slots_ff >= SLOT_LIMIT) begin
            brk_ff    <= 1'b1;
            closed_ff <= quads_ff;
         end else begin
            brk_ff    <= 1'b0;
            closed_ff <= '0;
         end
      end
      if (ram_rd) begin
         cmp_idx_ff <= idx_ff;
      end
      if (state_ff == ST_SEARCH) begin
         if (found) begin
            slot_ff <= cmp_idx_ff;
         end else if (miss) begin
            slot_ff <= slots_ff;
         end
      end
      if (load_sin) begin
         sin_ff <= trig_val;
      end
      if (load_cos) begin
         cos_ff <= trig_val;
      end
      if (do_mul) begin
         prod_ff[cnt_ff] <= mul_p;
      end
      if (do_emit) begin
         rsp_ff.vertex_x       <= vx_sat;
         rsp_ff.vertex_y       <= vy_sat;
         rsp_ff.vertex_z       <= req_ff.depth_z;
         rsp_ff.tex_u          <= cnt_ff[0];
         rsp_ff.tex_v          <= cnt_ff[1];
         rsp_ff.tex_slot       <= slot_ext[4:0];
         rsp_ff.vertex_color   <= req_ff.color_rgba;
         rsp_ff.batch_break    <= (cnt_ff == 2'd0) && brk_ff;
         rsp_ff.batch_end_only <= 1'b0;
         rsp_ff.closed_quads   <= (cnt_ff == 2'd0) ? closed_ext[16:0] : 17'd0;
         rsp_ff.last           <= (cnt_ff == 2'd3);
      end else if (do_end) begin
         rsp_ff.vertex_x       <= '0;
         rsp_ff.vertex_y       <= '0;
         rsp_ff.vertex_z       <= '0;
         rsp_ff.tex_u          <= 1'b0;
         rsp_ff.tex_v          <= 1'b0;
         rsp_ff.tex_slot       <= '0;
         rsp_ff.vertex_color   <= '0;
         rsp_ff.batch_break    <= 1'b1;
         rsp_ff.batch_end_only <= 1'b1;
         rsp_ff.closed_quads   <= closed_ext[16:0];
         rsp_ff.last           <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
